// ----- hw/rtl/ladrc_pkg.sv -----
// shared types, constants and saturation helpers for the ladrc controller
`timescale 1ns / 1ps

package ladrc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PLANT_GAIN  = 2'd0;
  localparam logic [1:0] CFG_PERIOD      = 2'd1;
  localparam logic [1:0] CFG_CTRL_BW     = 2'd2;
  localparam logic [1:0] CFG_OBS_BW      = 2'd3;

  // configuration reset values
  localparam logic [30:0] PLANT_GAIN_RST = 31'd131072;
  localparam logic [31:0] PERIOD_RST     = 32'd12884902;
  localparam logic [30:0] CTRL_BW_RST    = 31'd39321600;
  localparam logic [30:0] OBS_BW_RST     = 31'd393216;

  // drive limit of +-10000 in q16.16
  localparam logic [29:0]        DRIVE_LIMIT_MAG = 30'd655360000;
  localparam logic signed [30:0] DRIVE_LIMIT     = 31'sd655360000;

  // divider quotient bits once the overflow pre-check has passed
  localparam int unsigned DIV_BITS = 30;

  localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
  localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;
  localparam logic signed [31:0] SAT_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN  = 32'sh8000_0000;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_B2,  S_B2W,
    S_P,   S_PW,
    S_T1,  S_T1W,
    S_H1,  S_H1W,
    S_E2,
    S_T2,  S_T2W,
    S_H2,  S_H2W,
    S_T3,  S_T3W,
    S_DIV, S_DIVW,
    S_OUT
  } ladrc_state_t;

  // shared multiplier request and response
  typedef struct packed {
    logic               start;
    logic               shift_long;  // shift by 32 instead of 16
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] result;
  } mul_rsp_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic [30:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [30:0] drive;
    logic               clamped;
  } div_rsp_t;

  function automatic logic signed [31:0] sat_to_32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > WIDE_MAX) begin
      r = SAT_MAX;
    end else if (v < WIDE_MIN) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return sat_to_32(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) - 66'(b);
    return sat_to_32(s);
  endfunction

  function automatic logic signed [31:0] add3_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic signed [31:0] c);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b) + 66'(c);
    return sat_to_32(s);
  endfunction

endpackage

// ----- hw/rtl/ladrc_in_if.sv -----
// input channel: target and measured value per control period
`timescale 1ns / 1ps

interface ladrc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target;
  logic signed [31:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

// ----- hw/rtl/ladrc_out_if.sv -----
// result channel: drive, observer estimates and clamp flag
`timescale 1ns / 1ps

interface ladrc_out_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] drive;
  logic signed [31:0] position_estimate;
  logic signed [31:0] disturbance_estimate;
  logic               clamped;

  modport source (output valid, output drive, output position_estimate,
                  output disturbance_estimate, output clamped, input ready);
  modport sink   (input valid, input drive, input position_estimate,
                  input disturbance_estimate, input clamped, output ready);
endinterface

// ----- hw/rtl/ladrc_first_order_step.sv -----
// top level: observer and proportional law sequenced over a shared multiplier
//
//   channel   dir  payload                                            beat when
//   in_ch     in   target, measured                                   valid & ready
//   out_ch    out  drive, position_estimate, disturbance_estimate,    valid & ready
//                  clamped
//   cfg_*     in   cfg_index, cfg_data                                cfg_we high
//
// an item runs through seven multiplies on the one shared multiplier, then the
// 30-step divider, which finishes early when the quotient is known to clamp
// synchronous active-low reset restores the config defaults and clears the
// observer state and the last drive
// in_ch.ready is high only while idle; a result waiting on out_ch holds the
// next one in its final state, which keeps in_ch.ready low until it is loaded
`timescale 1ns / 1ps

module ladrc_first_order_step (
  input  logic        clk,
  input  logic        rst_n,
  ladrc_in_if.sink    in_ch,
  ladrc_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [30:0] b0_r;
  logic [31:0] h_r;
  logic [30:0] wc_r;
  logic [30:0] w0_r;

  ladrc_pkg::ladrc_state_t state_r, state_nxt;

  logic signed [31:0] target_r, target_nxt;
  logic signed [31:0] measured_r, measured_nxt;
  logic signed [31:0] beta1_r, beta1_nxt;
  logic signed [31:0] beta2_r, beta2_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [31:0] err3_r, err3_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] est_o_r, est_o_nxt;
  logic signed [31:0] est_d_r, est_d_nxt;
  logic signed [31:0] last_drive_r, last_drive_nxt;
  logic               clamp_r, clamp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [30:0] out_drive_r, out_drive_nxt;
  logic signed [31:0] out_pos_r, out_pos_nxt;
  logic signed [31:0] out_dist_r, out_dist_nxt;
  logic               out_clamp_r, out_clamp_nxt;

  ladrc_pkg::mul_req_t mul_req;
  ladrc_pkg::mul_rsp_t mul_rsp;
  ladrc_pkg::div_req_t div_req;
  ladrc_pkg::div_rsp_t div_rsp;

  ladrc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  ladrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= ladrc_pkg::PLANT_GAIN_RST;
      h_r  <= ladrc_pkg::PERIOD_RST;
      wc_r <= ladrc_pkg::CTRL_BW_RST;
      w0_r <= ladrc_pkg::OBS_BW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ladrc_pkg::CFG_PLANT_GAIN: b0_r <= cfg_data[30:0];
        ladrc_pkg::CFG_PERIOD:     h_r  <= cfg_data;
        ladrc_pkg::CFG_CTRL_BW:    wc_r <= cfg_data[30:0];
        ladrc_pkg::CFG_OBS_BW:     w0_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ladrc_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      est_o_r      <= '0;
      est_d_r      <= '0;
      last_drive_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      est_o_r      <= est_o_nxt;
      est_d_r      <= est_d_nxt;
      last_drive_r <= last_drive_nxt;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    measured_r  <= measured_nxt;
    beta1_r     <= beta1_nxt;
    beta2_r     <= beta2_nxt;
    err_r       <= err_nxt;
    err3_r      <= err3_nxt;
    acc_r       <= acc_nxt;
    clamp_r     <= clamp_nxt;
    out_drive_r <= out_drive_nxt;
    out_pos_r   <= out_pos_nxt;
    out_dist_r  <= out_dist_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  // sequencer: next state, unit requests and register updates
  always_comb begin
    state_nxt      = state_r;
    target_nxt     = target_r;
    measured_nxt   = measured_r;
    beta1_nxt      = beta1_r;
    beta2_nxt      = beta2_r;
    err_nxt        = err_r;
    err3_nxt       = err3_r;
    acc_nxt        = acc_r;
    est_o_nxt      = est_o_r;
    est_d_nxt      = est_d_r;
    last_drive_nxt = last_drive_r;
    clamp_nxt      = clamp_r;
    out_drive_nxt  = out_drive_r;
    out_pos_nxt    = out_pos_r;
    out_dist_nxt   = out_dist_r;
    out_clamp_nxt  = out_clamp_r;
    mul_req        = '0;
    div_req        = '0;

    // result taken
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ladrc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          target_nxt   = in_ch.target;
          measured_nxt = in_ch.measured;
          state_nxt    = ladrc_pkg::S_B2;
        end
      end
      // beta2 = w0 * w0, beta1 = 2 * w0 saturated
      ladrc_pkg::S_B2: begin
        mul_req.start = 1'b1;
        mul_req.a     = {2'b0, w0_r};
        mul_req.b     = {2'b0, w0_r};
        beta1_nxt     = w0_r[30] ? ladrc_pkg::SAT_MAX : $signed({w0_r, 1'b0});
        state_nxt     = ladrc_pkg::S_B2W;
      end
      ladrc_pkg::S_B2W: begin
        if (mul_rsp.done) begin
          beta2_nxt = mul_rsp.result;
          state_nxt = ladrc_pkg::S_P;
        end
      end
      // b0 * last drive, and first observer error
      ladrc_pkg::S_P: begin
        mul_req.start = 1'b1;
        mul_req.a     = {2'b0, b0_r};
        mul_req.b     = 33'(last_drive_r);
        err_nxt       = ladrc_pkg::sub_sat(measured_r, est_o_r);
        state_nxt     = ladrc_pkg::S_PW;
      end
      ladrc_pkg::S_PW: begin
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.result;
          state_nxt = ladrc_pkg::S_T1;
        end
      end
      // beta1 * error, summed with disturbance and b0 term
      ladrc_pkg::S_T1: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(beta1_r);
        mul_req.b     = 33'(err_r);
        state_nxt     = ladrc_pkg::S_T1W;
      end
      ladrc_pkg::S_T1W: begin
        if (mul_rsp.done) begin
          acc_nxt   = ladrc_pkg::add3_sat(est_d_r, acc_r, mul_rsp.result);
          state_nxt = ladrc_pkg::S_H1;
        end
      end
      // position estimate update
      ladrc_pkg::S_H1: begin
        mul_req.start      = 1'b1;
        mul_req.shift_long = 1'b1;
        mul_req.a          = 33'(acc_r);
        mul_req.b          = {1'b0, h_r};
        state_nxt          = ladrc_pkg::S_H1W;
      end
      ladrc_pkg::S_H1W: begin
        if (mul_rsp.done) begin
          est_o_nxt = ladrc_pkg::add_sat(est_o_r, mul_rsp.result);
          state_nxt = ladrc_pkg::S_E2;
        end
      end
      // errors against the updated position estimate
      ladrc_pkg::S_E2: begin
        err_nxt   = ladrc_pkg::sub_sat(measured_r, est_o_r);
        err3_nxt  = ladrc_pkg::sub_sat(target_r, est_o_r);
        state_nxt = ladrc_pkg::S_T2;
      end
      ladrc_pkg::S_T2: begin
        mul_req.start = 1'b1;
        mul_req.a     = 33'(beta2_r);
        mul_req.b     = 33'(err_r);
        state_nxt     = ladrc_pkg::S_T2W;
      end
      ladrc_pkg::S_T2W: begin
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.result;
          state_nxt = ladrc_pkg::S_H2;
        end
      end
      // disturbance estimate update
      ladrc_pkg::S_H2: begin
        mul_req.start      = 1'b1;
        mul_req.shift_long = 1'b1;
        mul_req.a          = 33'(acc_r);
        mul_req.b          = {1'b0, h_r};
        state_nxt          = ladrc_pkg::S_H2W;
      end
      ladrc_pkg::S_H2W: begin
        if (mul_rsp.done) begin
          est_d_nxt = ladrc_pkg::add_sat(est_d_r, mul_rsp.result);
          state_nxt = ladrc_pkg::S_T3;
        end
      end
      // proportional law numerator
      ladrc_pkg::S_T3: begin
        mul_req.start = 1'b1;
        mul_req.a     = {2'b0, wc_r};
        mul_req.b     = 33'(err3_r);
        state_nxt     = ladrc_pkg::S_T3W;
      end
      ladrc_pkg::S_T3W: begin
        if (mul_rsp.done) begin
          acc_nxt   = ladrc_pkg::sub_sat(mul_rsp.result, est_d_r);
          state_nxt = ladrc_pkg::S_DIV;
        end
      end
      // divide by b0 and clamp
      ladrc_pkg::S_DIV: begin
        div_req.start   = 1'b1;
        div_req.num     = acc_r;
        div_req.divisor = b0_r;
        state_nxt       = ladrc_pkg::S_DIVW;
      end
      ladrc_pkg::S_DIVW: begin
        if (div_rsp.done) begin
          last_drive_nxt = 32'(div_rsp.drive);
          clamp_nxt      = div_rsp.clamped;
          state_nxt      = ladrc_pkg::S_OUT;
        end
      end
      // load the output register once it is free
      ladrc_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = last_drive_r[30:0];
          out_pos_nxt   = est_o_r;
          out_dist_nxt  = est_d_r;
          out_clamp_nxt = clamp_r;
          state_nxt     = ladrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ladrc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ch.ready                 = (state_r == ladrc_pkg::S_IDLE);
  assign out_ch.valid                = out_valid_r;
  assign out_ch.drive                = out_drive_r;
  assign out_ch.position_estimate    = out_pos_r;
  assign out_ch.disturbance_estimate = out_dist_r;
  assign out_ch.clamped              = out_clamp_r;

  // multiplier results only arrive while the sequencer waits for them
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == ladrc_pkg::S_B2W || state_r == ladrc_pkg::S_PW ||
                      state_r == ladrc_pkg::S_T1W || state_r == ladrc_pkg::S_H1W ||
                      state_r == ladrc_pkg::S_T2W || state_r == ladrc_pkg::S_H2W ||
                      state_r == ladrc_pkg::S_T3W))
    else $error("multiplier result outside a wait state");

  // divider result only arrives while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ladrc_pkg::S_DIVW)
    else $error("divider result outside its wait state");

  // presented drive stays within the limit
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive <= ladrc_pkg::DRIVE_LIMIT &&
                      out_ch.drive >= -ladrc_pkg::DRIVE_LIMIT))
    else $error("drive beyond limit");

  // a clamped drive sits exactly on the limit
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.clamped) |-> (out_ch.drive == ladrc_pkg::DRIVE_LIMIT ||
                                          out_ch.drive == -ladrc_pkg::DRIVE_LIMIT))
    else $error("clamp flag set with drive off the limit");

endmodule

// ----- hw/rtl/ladrc_mul.sv -----
// shared signed multiplier with floored shift and 32-bit saturation
`timescale 1ns / 1ps

module ladrc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  ladrc_pkg::mul_req_t req,
  output ladrc_pkg::mul_rsp_t rsp
);

  logic                      v1_r;
  logic                      done_r;
  logic                      long_r;
  logic signed [65:0]        prod_r;
  logic signed [31:0]        res_r;
  logic signed [65:0]        shifted;

  // control pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      done_r <= v1_r;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign shifted = long_r ? (prod_r >>> 32) : (prod_r >>> 16);

  // product stage, then shift and saturate stage
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= req.a * req.b;
      long_r <= req.shift_long;
    end
    if (v1_r) begin
      res_r <= ladrc_pkg::sat_to_32(shifted);
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ----- hw/rtl/ladrc_div.sv -----
// bit-serial divider for (num * 2^16) / b0 with drive clamping
`timescale 1ns / 1ps

module ladrc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ladrc_pkg::div_req_t req,
  output ladrc_pkg::div_rsp_t rsp
);

  localparam logic [29:0] DRIVE_LIMIT_MAG_LOCAL = ladrc_pkg::DRIVE_LIMIT_MAG;

  logic                busy_r;
  logic                fin_r;
  logic                done_r;
  logic [4:0]          cnt_r;
  logic [30:0]         dsr_r;
  logic [30:0]         rem_r;
  logic [29:0]         quo_r;
  logic                neg_r;
  logic                ovf_r;
  logic signed [30:0]  drive_r;
  logic                clamped_r;

  logic [30:0]         dsr;
  logic [31:0]         mag;
  logic                ovf;
  logic [31:0]         trial;
  logic [31:0]         diff;
  logic                ge;
  logic                over;
  logic [29:0]         mag_o;
  logic signed [30:0]  mag_s;

  // zero gain acts as one lsb
  assign dsr = (req.divisor == 31'd0) ? 31'd1 : req.divisor;
  assign mag = req.num[31] ? (~req.num + 32'd1) : req.num;
  // quotient reaches 2^30 or more, so it clamps anyway
  assign ovf = {13'b0, mag} >= {dsr, 14'b0};

  // restoring step: shift in next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_r[29]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  // clamp and sign fix-up
  assign over  = ovf_r || (quo_r > DRIVE_LIMIT_MAG_LOCAL);
  assign mag_o = over ? DRIVE_LIMIT_MAG_LOCAL : quo_r;
  assign mag_s = $signed({1'b0, mag_o});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.start) begin
        cnt_r <= 5'(ladrc_pkg::DIV_BITS - 1);
        if (ovf) begin
          fin_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr_r <= dsr;
      neg_r <= req.num[31];
      ovf_r <= ovf;
      rem_r <= {13'b0, mag[31:14]};
      quo_r <= {mag[13:0], 16'b0};
    end else if (busy_r) begin
      rem_r <= ge ? diff[30:0] : trial[30:0];
      quo_r <= {quo_r[28:0], ge};
    end
    if (fin_r) begin
      drive_r   <= neg_r ? -mag_s : mag_s;
      clamped_r <= over;
    end
  end

  assign rsp.done    = done_r;
  assign rsp.drive   = drive_r;
  assign rsp.clamped = clamped_r;

endmodule

// ----- sim/ladrc_first_order_step_test.sv -----
// testbench for ladrc_first_order_step: predicts each control period and checks every result beat
`timescale 1ns / 1ps

module ladrc_first_order_step_test;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 60;      // a little over one full item latency
  localparam int CHUNK_ITEMS   = 65;
  localparam int MAX_SHOWN     = 10;
  localparam longint DRIVE_CAP = 655360000;
  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

  typedef struct {
    logic signed [30:0] drive;
    logic signed [31:0] position;
    logic signed [31:0] disturbance;
    logic               clamped;
  } period_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  ladrc_in_if  in_ch ();
  ladrc_out_if out_ch ();

  ladrc_first_order_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // controller settings and observer state as the block should hold them
  logic [30:0]        b0_reg = ladrc_pkg::PLANT_GAIN_RST;
  logic [31:0]        h_reg  = ladrc_pkg::PERIOD_RST;
  logic [30:0]        wc_reg = ladrc_pkg::CTRL_BW_RST;
  logic [30:0]        w0_reg = ladrc_pkg::OBS_BW_RST;
  logic signed [31:0] pos_est    = '0;
  logic signed [31:0] dist_est   = '0;
  logic signed [31:0] prev_drive = '0;

  period_result_t predicted_outputs[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          stall_hold = 0;
  int unsigned cycle_count = 0;

  always #HALF_PERIOD clk = ~clk;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] clip32(input longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // q16.16 product, floored and saturated
  function automatic logic signed [31:0] qmul16(input longint a, input longint b);
    return clip32((a * b) >>> 16);
  endfunction

  // product with the unsigned q0.32 step period
  function automatic logic signed [31:0] mul_period(input logic signed [31:0] a);
    return clip32((longint'(a) * longint'(h_reg)) >>> 32);
  endfunction

  // one control period: observer update, then proportional law and clamp
  function automatic period_result_t step_controller(input logic signed [31:0] tgt,
                                                     input logic signed [31:0] meas);
    longint beta1, beta2, err, term, sum, num, divisor, quot;
    period_result_t r;
    beta1 = clip32(2 * longint'(w0_reg));
    beta2 = qmul16(longint'(w0_reg), longint'(w0_reg));

    err  = clip32(longint'(meas) - longint'(pos_est));
    term = qmul16(beta1, err);
    sum  = clip32(longint'(dist_est)
                  + longint'(qmul16(longint'(b0_reg), longint'(prev_drive))) + term);
    pos_est = clip32(longint'(pos_est) + longint'(mul_period(sum[31:0])));

    // disturbance uses the freshly updated position estimate
    err  = clip32(longint'(meas) - longint'(pos_est));
    term = qmul16(beta2, err);
    dist_est = clip32(longint'(dist_est) + longint'(mul_period(term[31:0])));

    err  = clip32(longint'(tgt) - longint'(pos_est));
    term = qmul16(longint'(wc_reg), err);
    num  = clip32(term - longint'(dist_est));
    divisor = (b0_reg == '0) ? 64'sd1 : longint'(b0_reg);
    quot = (num * 65536) / divisor;

    r.clamped = 1'b0;
    if (quot > DRIVE_CAP) begin
      quot = DRIVE_CAP;
      r.clamped = 1'b1;
    end else if (quot < -DRIVE_CAP) begin
      quot = -DRIVE_CAP;
      r.clamped = 1'b1;
    end
    prev_drive    = quot[31:0];
    r.drive       = quot[30:0];
    r.position    = pos_est;
    r.disturbance = dist_est;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", msg);
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    period_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_outputs.size() == 0) begin
        flag_error($sformatf("unexpected result beat: drive %0d pos %0d dist %0d clamped %0b",
                             out_ch.drive, out_ch.position_estimate,
                             out_ch.disturbance_estimate, out_ch.clamped));
      end else begin
        want = predicted_outputs.pop_front();
        if (out_ch.drive !== want.drive || out_ch.position_estimate !== want.position ||
            out_ch.disturbance_estimate !== want.disturbance ||
            out_ch.clamped !== want.clamped) begin
          flag_error($sformatf({"result mismatch: drive %0d/%0d pos %0d/%0d dist %0d/%0d",
                                " clamped %0b/%0b (expected/actual)"},
                               want.drive, out_ch.drive, want.position,
                               out_ch.position_estimate, want.disturbance,
                               out_ch.disturbance_estimate, want.clamped, out_ch.clamped));
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side back-pressure, with occasional long holds
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
      out_ch.ready <= 1'b0;
    end else if (receiver_stall_pct != 0 && $urandom_range(199) == 0) begin
      stall_hold = $urandom_range(120, 20);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // present one period beat and predict its result once accepted
  task automatic send_period(input logic signed [31:0] tgt, input logic signed [31:0] meas);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(90, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.target   <= tgt;
    in_ch.measured <= meas;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_outputs.push_back(step_controller(tgt, meas));
  endtask

  // hold off until every predicted result has come back
  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ladrc_pkg::CFG_PLANT_GAIN: b0_reg = value[30:0];
      ladrc_pkg::CFG_PERIOD:     h_reg  = value;
      ladrc_pkg::CFG_CTRL_BW:    wc_reg = value[30:0];
      ladrc_pkg::CFG_OBS_BW:     w0_reg = value[30:0];
      default: ;
    endcase
  endtask

  task automatic restore_defaults();
    write_setting(ladrc_pkg::CFG_PLANT_GAIN, 32'(ladrc_pkg::PLANT_GAIN_RST));
    write_setting(ladrc_pkg::CFG_PERIOD, ladrc_pkg::PERIOD_RST);
    write_setting(ladrc_pkg::CFG_CTRL_BW, 32'(ladrc_pkg::CTRL_BW_RST));
    write_setting(ladrc_pkg::CFG_OBS_BW, 32'(ladrc_pkg::OBS_BW_RST));
  endtask

  // unity gains with a frozen observer: drive equals target, so the limit is hit exactly
  task automatic test_drive_limit();
    wait_until_drained();
    write_setting(ladrc_pkg::CFG_PLANT_GAIN, Q_ONE);
    write_setting(ladrc_pkg::CFG_PERIOD, 32'd0);
    write_setting(ladrc_pkg::CFG_CTRL_BW, Q_ONE);
    write_setting(ladrc_pkg::CFG_OBS_BW, 32'd0);
    send_period(32'(DRIVE_CAP), 32'sd0);
    send_period(32'(DRIVE_CAP + 1), 32'sd0);
    send_period(32'(-DRIVE_CAP), 32'sd0);
    send_period(32'(-DRIVE_CAP - 1), 32'sd0);
    send_period(32'sd0, 32'sd0);
    send_period(3 * Q_ONE, Q_ONE);
  endtask

  // zero plant gain acts as one lsb
  task automatic test_zero_gain();
    wait_until_drained();
    restore_defaults();
    write_setting(ladrc_pkg::CFG_PLANT_GAIN, 32'd0);
    send_period(32'sd0, 32'sd0);
    send_period(Q_ONE, 32'sd0);
    send_period(-Q_ONE, 32'sd0);
    send_period(32'sd0, Q_ONE);
  endtask

  task automatic test_default_extremes();
    wait_until_drained();
    restore_defaults();
    send_period(32'sd0, 32'sd0);
    send_period(Q_MAX, Q_MAX);
    send_period(Q_MIN, Q_MIN);
    send_period(Q_MAX, Q_MIN);
    send_period(Q_MIN, Q_MAX);
    send_period(5 * Q_ONE, 32'sd0);
  endtask

  // largest and smallest settings, driving intermediates into saturation with the largest
  task automatic test_saturation_extremes();
    wait_until_drained();
    write_setting(ladrc_pkg::CFG_PLANT_GAIN, 32'hFFFF_FFFF);
    write_setting(ladrc_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
    write_setting(ladrc_pkg::CFG_CTRL_BW, 32'hFFFF_FFFF);
    write_setting(ladrc_pkg::CFG_OBS_BW, 32'hFFFF_FFFF);
    send_period(Q_MAX, Q_MIN);
    send_period(Q_MIN, Q_MAX);
    send_period(Q_MAX, Q_MAX);
    send_period(32'sd0, 32'sd0);
    wait_until_drained();
    write_setting(ladrc_pkg::CFG_PLANT_GAIN, 32'd1);
    write_setting(ladrc_pkg::CFG_PERIOD, 32'd0);
    write_setting(ladrc_pkg::CFG_CTRL_BW, 32'd0);
    write_setting(ladrc_pkg::CFG_OBS_BW, 32'd0);
    send_period(Q_MAX, Q_MIN);
    send_period(Q_MIN, Q_MAX);
    send_period(32'sd0, 32'sd0);
  endtask

  // mostly tracking traffic around the current estimate, some full-range and corner beats
  task automatic test_closed_loop_traffic(input int idle_pct, input int stall_pct);
    int kind;
    logic signed [31:0] tgt, meas;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_until_drained();
      case (chunk)
        0: restore_defaults();
        3: begin
          write_setting(ladrc_pkg::CFG_PLANT_GAIN, $urandom());
          write_setting(ladrc_pkg::CFG_PERIOD, $urandom());
          write_setting(ladrc_pkg::CFG_CTRL_BW, $urandom());
          write_setting(ladrc_pkg::CFG_OBS_BW, $urandom());
        end
        default: begin
          write_setting(ladrc_pkg::CFG_PLANT_GAIN, $urandom_range(1 << 20, 1 << 12));
          write_setting(ladrc_pkg::CFG_PERIOD, $urandom_range(1 << 27, 1 << 20));
          write_setting(ladrc_pkg::CFG_CTRL_BW, $urandom_range(1 << 26));
          write_setting(ladrc_pkg::CFG_OBS_BW, $urandom_range(1 << 22));
        end
      endcase
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          meas = clip32(longint'(pos_est) + longint'($urandom_range(1 << 18)) - (1 << 17));
          tgt  = clip32(longint'(pos_est) + longint'($urandom_range(1 << 24)) - (1 << 23));
        end else if (kind < 90) begin
          tgt  = $urandom();
          meas = $urandom();
        end else begin
          tgt  = $urandom_range(1) ? ($urandom_range(1) ? Q_MAX : Q_MIN) : -32'sd1;
          meas = $urandom_range(1) ? ($urandom_range(1) ? Q_MAX : Q_MIN) : 32'sd0;
        end
        send_period(tgt, meas);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ladrc_pkg::CFG_PLANT_GAIN;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.target   = '0;
    in_ch.measured = '0;
    out_ch.ready   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_drive_limit();
    test_zero_gain();
    test_default_extremes();
    test_saturation_extremes();
    test_closed_loop_traffic(0, 0);
    test_closed_loop_traffic(76, 0);
    test_closed_loop_traffic(0, 76);
    test_closed_loop_traffic(33, 33);

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
